>>> design/c_source_nesting_skipper_assert.svh
// Assertion macros shared by the RTL of the nesting skipper.
`ifndef C_SOURCE_NESTING_SKIPPER_ASSERT_SVH
`define C_SOURCE_NESTING_SKIPPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CNS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("cns assertion failed");

// Next-cycle implication, checked outside reset.
`define CNS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("cns assertion failed");

`endif

>>> design/cns_pkg.sv
`timescale 1ns / 1ps

package cns_pkg;

	// Default stack depth
	localparam int MAX_NEST_DEF = 32;

	// Fixed field widths
	localparam int BYTE_W        = 8;
	localparam int NEST_DEPTH_W  = 6;

	typedef logic [BYTE_W-1:0] byte_t;

	// Characters of interest
	localparam byte_t CH_SLASH  = 8'h2F;
	localparam byte_t CH_HASH   = 8'h23;
	localparam byte_t CH_LPAREN = 8'h28;
	localparam byte_t CH_RPAREN = 8'h29;
	localparam byte_t CH_LBRACK = 8'h5B;
	localparam byte_t CH_RBRACK = 8'h5D;
	localparam byte_t CH_LBRACE = 8'h7B;
	localparam byte_t CH_RBRACE = 8'h7D;
	localparam byte_t CH_STAR   = 8'h2A;
	localparam byte_t CH_NL     = 8'h0A;
	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_DQUOTE = 8'h22;
	localparam byte_t CH_SQUOTE = 8'h27;

	// Region class reported per byte
	typedef enum logic [1:0] {
		KIND_CODE      = 2'd0,
		KIND_COMMENT   = 2'd1,
		KIND_LITERAL   = 2'd2,
		KIND_DIRECTIVE = 2'd3
	} kind_t;

	// Expected closer kept on the stack
	typedef enum logic [1:0] {
		CL_PAREN   = 2'd0,
		CL_BRACKET = 2'd1,
		CL_BRACE   = 2'd2
	} closer_t;

	// Scanner sub-mode, one-hot
	typedef enum logic [7:0] {
		SUB_PLAIN  = 8'b0000_0001,
		SUB_SLASH  = 8'b0000_0010,
		SUB_LINE   = 8'b0000_0100,
		SUB_BLOCK  = 8'b0000_1000,
		SUB_STAR   = 8'b0001_0000,
		SUB_LIT    = 8'b0010_0000,
		SUB_LITESC = 8'b0100_0000,
		SUB_DIRESC = 8'b1000_0000
	} sub_t;

	// Lexer decision for one byte
	typedef struct packed {
		sub_t    n_sub;
		logic    n_dir;
		logic    n_quote;
		kind_t   kind;
		logic    push;
		logic    pop;
		logic    ovf;
		closer_t code;
	} scan_res_t;

endpackage

>>> design/cns_in_if.sv
`timescale 1ns / 1ps

// Source text channel
interface cns_in_if;
	logic          valid;
	logic          ready;
	cns_pkg::byte_t text_byte;
	logic          end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> design/cns_out_if.sv
`timescale 1ns / 1ps

// Per-byte classification channel
interface cns_out_if;
	logic                                valid;
	logic                                ready;
	logic                                at_outer_level;
	logic [cns_pkg::NEST_DEPTH_W-1:0]    nest_depth;
	logic [1:0]                          region_kind;
	logic                                depth_overflow;

	modport source (output valid, output at_outer_level, output nest_depth,
		output region_kind, output depth_overflow, input ready);
	modport sink   (input valid, input at_outer_level, input nest_depth,
		input region_kind, input depth_overflow, output ready);
endinterface

>>> design/cns_stack_ram.sv
`timescale 1ns / 1ps

// Closer stack storage: one write port, one registered read port.
// A read of the address written in the same cycle returns the new data.
module cns_stack_ram #(
	parameter int DEPTH = cns_pkg::MAX_NEST_DEF,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  cns_pkg::closer_t wdata,
	input  logic [AW-1:0]    raddr,
	output cns_pkg::closer_t rdata
);

	cns_pkg::closer_t mem [DEPTH];
	cns_pkg::closer_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, write-first on address match
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/cns_lexer.sv
`timescale 1ns / 1ps

// Per-byte lexer decision: next mode, region class and stack operation.
module cns_lexer #(
	parameter int MAX_NEST = cns_pkg::MAX_NEST_DEF,
	parameter int LW       = 6
) (
	input  cns_pkg::byte_t    ch,
	input  cns_pkg::sub_t     sub,
	input  logic              dir,
	input  logic              quote,
	input  logic [LW-1:0]     level,
	input  cns_pkg::closer_t  top,
	output cns_pkg::scan_res_t res
);

	logic           plain;
	logic           plain_dir;
	cns_pkg::byte_t quote_byte;
	logic           is_open;
	logic           is_close;
	cns_pkg::closer_t br_code;

	assign quote_byte = quote ? cns_pkg::CH_SQUOTE : cns_pkg::CH_DQUOTE;

	// Bracket decode
	always_comb begin
		is_open  = 1'b0;
		is_close = 1'b0;
		br_code  = cns_pkg::CL_PAREN;
		unique case (ch)
			cns_pkg::CH_LPAREN: begin is_open  = 1'b1; br_code = cns_pkg::CL_PAREN;   end
			cns_pkg::CH_LBRACK: begin is_open  = 1'b1; br_code = cns_pkg::CL_BRACKET; end
			cns_pkg::CH_LBRACE: begin is_open  = 1'b1; br_code = cns_pkg::CL_BRACE;   end
			cns_pkg::CH_RPAREN: begin is_close = 1'b1; br_code = cns_pkg::CL_PAREN;   end
			cns_pkg::CH_RBRACK: begin is_close = 1'b1; br_code = cns_pkg::CL_BRACKET; end
			cns_pkg::CH_RBRACE: begin is_close = 1'b1; br_code = cns_pkg::CL_BRACE;   end
			default: ;
		endcase
	end

	always_comb begin
		res         = '0;
		res.n_sub   = sub;
		res.n_dir   = dir;
		res.n_quote = quote;
		res.kind    = cns_pkg::KIND_CODE;
		res.code    = br_code;
		plain       = 1'b0;
		plain_dir   = dir;

		// Sub-mode transitions
		unique case (sub)
			cns_pkg::SUB_SLASH: begin
				if (ch == cns_pkg::CH_SLASH) begin
					res.n_sub = cns_pkg::SUB_LINE;
					res.kind  = cns_pkg::KIND_COMMENT;
				end else if (ch == cns_pkg::CH_STAR) begin
					res.n_sub = cns_pkg::SUB_BLOCK;
					res.kind  = cns_pkg::KIND_COMMENT;
				end else begin
					plain = 1'b1;
				end
			end
			cns_pkg::SUB_LINE: begin
				res.kind = cns_pkg::KIND_COMMENT;
				if (ch == cns_pkg::CH_NL) begin
					res.n_sub = cns_pkg::SUB_PLAIN;
					res.n_dir = 1'b0;
				end
			end
			cns_pkg::SUB_BLOCK: begin
				res.kind = cns_pkg::KIND_COMMENT;
				if (ch == cns_pkg::CH_STAR) begin
					res.n_sub = cns_pkg::SUB_STAR;
				end
			end
			cns_pkg::SUB_STAR: begin
				res.kind = cns_pkg::KIND_COMMENT;
				if (ch == cns_pkg::CH_SLASH) begin
					res.n_sub = cns_pkg::SUB_PLAIN;
				end else if (ch != cns_pkg::CH_STAR) begin
					res.n_sub = cns_pkg::SUB_BLOCK;
				end
			end
			cns_pkg::SUB_LIT: begin
				res.kind = cns_pkg::KIND_LITERAL;
				if (ch == cns_pkg::CH_BSLASH) begin
					res.n_sub = cns_pkg::SUB_LITESC;
				end else if (ch == quote_byte) begin
					res.n_sub = cns_pkg::SUB_PLAIN;
				end
			end
			cns_pkg::SUB_LITESC: begin
				res.kind  = cns_pkg::KIND_LITERAL;
				res.n_sub = cns_pkg::SUB_LIT;
			end
			cns_pkg::SUB_DIRESC: begin
				if (dir) begin
					res.kind  = cns_pkg::KIND_DIRECTIVE;
					res.n_sub = cns_pkg::SUB_PLAIN;
				end else begin
					// escape outside a directive: plain code
					plain     = 1'b1;
					plain_dir = 1'b0;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase

		// Ordinary byte in code or directive context
		if (plain) begin
			res.n_sub = cns_pkg::SUB_PLAIN;
			res.n_dir = plain_dir;
			if (plain_dir) begin
				res.kind = cns_pkg::KIND_DIRECTIVE;
				if (ch == cns_pkg::CH_NL) begin
					res.n_dir = 1'b0;
				end else if (ch == cns_pkg::CH_BSLASH) begin
					res.n_sub = cns_pkg::SUB_DIRESC;
				end else if (ch == cns_pkg::CH_DQUOTE || ch == cns_pkg::CH_SQUOTE) begin
					res.n_quote = (ch == cns_pkg::CH_SQUOTE);
					res.n_sub   = cns_pkg::SUB_LIT;
					res.kind    = cns_pkg::KIND_LITERAL;
				end else if (ch == cns_pkg::CH_SLASH) begin
					res.n_sub = cns_pkg::SUB_SLASH;
				end
			end else begin
				res.kind = cns_pkg::KIND_CODE;
				if (ch == cns_pkg::CH_SLASH) begin
					res.n_sub = cns_pkg::SUB_SLASH;
				end else if (ch == cns_pkg::CH_DQUOTE || ch == cns_pkg::CH_SQUOTE) begin
					res.n_quote = (ch == cns_pkg::CH_SQUOTE);
					res.n_sub   = cns_pkg::SUB_LIT;
					res.kind    = cns_pkg::KIND_LITERAL;
				end else if (ch == cns_pkg::CH_HASH) begin
					res.n_dir = 1'b1;
					res.kind  = cns_pkg::KIND_DIRECTIVE;
				end else if (is_open) begin
					if (level < LW'(MAX_NEST)) begin
						res.push = 1'b1;
					end else begin
						res.ovf = 1'b1;
					end
				end else if (is_close) begin
					res.pop = (level != '0) && (top == br_code);
				end
			end
		end
	end

endmodule

>>> design/c_source_nesting_skipper.sv
`timescale 1ns / 1ps

// C source nesting skipper. Takes one source byte per clock and returns one
// classification per byte (outer-level flag, bracket depth before the byte,
// region class, sticky overflow) in the cycle after the byte is taken. A byte
// can be taken every cycle while the result side keeps up; a result left
// waiting in the output register holds off the input until it is taken, and
// a byte is still accepted in the same cycle that the waiting result leaves.
// The innermost expected closer sits in a register; deeper entries
// live in a single-port-write RAM with registered read that is read one level
// ahead, so a pop always finds the next closer ready. No clearing pass follows
// reset. An opener at full depth is ignored as plain code and sets the sticky
// overflow flag. A byte marked end_of_text resets mode, flags and level.
module c_source_nesting_skipper #(
	parameter int MAX_NEST = cns_pkg::MAX_NEST_DEF
) (
	input logic      clk,
	input logic      arst_n,
	cns_in_if.sink   text,
	cns_out_if.source result
);

`include "c_source_nesting_skipper_assert.svh"

	localparam int LW = $clog2(MAX_NEST + 1);
	localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

	// Scanner state
	cns_pkg::sub_t    sub_q;
	logic             dir_q;
	logic             quote_q;
	logic [LW-1:0]    level_q;
	cns_pkg::closer_t top_q;
	logic             ovf_q;
	cns_pkg::closer_t below;

	// Output register
	logic                             out_valid_q;
	logic                             outer_q;
	logic [cns_pkg::NEST_DEPTH_W-1:0] depth_q;
	cns_pkg::kind_t                   kind_q;
	logic                             ovf_out_q;

	cns_pkg::scan_res_t st;
	logic               accept;
	logic [LW-1:0]      level_nx;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;

	assign text.ready = !out_valid_q || result.ready;
	assign accept     = text.valid && text.ready;

	cns_lexer #(
		.MAX_NEST (MAX_NEST),
		.LW       (LW)
	) u_lexer (
		.ch    (text.text_byte),
		.sub   (sub_q),
		.dir   (dir_q),
		.quote (quote_q),
		.level (level_q),
		.top   (top_q),
		.res   (st)
	);

	// Next stack level
	always_comb begin
		level_nx = level_q;
		if (accept) begin
			if (text.end_of_text) begin
				level_nx = '0;
			end else if (st.push) begin
				level_nx = level_q + LW'(1);
			end else if (st.pop) begin
				level_nx = level_q - LW'(1);
			end
		end
	end

	// Spill the old top on push; read ahead the entry under the next top
	assign ram_we    = accept && st.push && (level_q != '0);
	assign ram_waddr = AW'(level_q - LW'(1));
	assign ram_raddr = AW'(level_nx - LW'(2));

	cns_stack_ram #(
		.DEPTH (MAX_NEST),
		.AW    (AW)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (top_q),
		.raddr (ram_raddr),
		.rdata (below)
	);

	// Scanner state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q   <= cns_pkg::SUB_PLAIN;
			dir_q   <= 1'b0;
			quote_q <= 1'b0;
			level_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			level_q <= level_nx;
			if (text.end_of_text) begin
				sub_q   <= cns_pkg::SUB_PLAIN;
				dir_q   <= 1'b0;
				quote_q <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				sub_q   <= st.n_sub;
				dir_q   <= st.n_dir;
				quote_q <= st.n_quote;
				ovf_q   <= ovf_q | st.ovf;
			end
		end
	end

	// Top-of-stack register
	always_ff @(posedge clk) begin
		if (accept) begin
			if (st.push) begin
				top_q <= st.code;
			end else if (st.pop) begin
				top_q <= below;
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			outer_q   <= (st.kind == cns_pkg::KIND_CODE) && (level_q == '0);
			depth_q   <= cns_pkg::NEST_DEPTH_W'(level_q);
			kind_q    <= st.kind;
			ovf_out_q <= ovf_q | st.ovf;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.at_outer_level = outer_q;
	assign result.nest_depth     = depth_q;
	assign result.region_kind    = kind_q;
	assign result.depth_overflow = ovf_out_q;

	`CNS_ASSERT_IMP(a_level_bound, clk, arst_n, 1'b1, level_q <= LW'(MAX_NEST))
	`CNS_ASSERT_IMP(a_push_pop_excl, clk, arst_n, accept, !(st.push && st.pop))
	`CNS_ASSERT_NXT(a_eot_clears, clk, arst_n, accept && text.end_of_text, (level_q == '0) && !dir_q && !ovf_q)
	`CNS_ASSERT_NXT(a_accept_gives_result, clk, arst_n, accept, out_valid_q)

endmodule

>>> dv/tb_c_source_nesting_skipper.sv
`timescale 1ns / 1ps

module tb_c_source_nesting_skipper;
	import cns_pkg::*;

	localparam int          MAX_NEST     = MAX_NEST_DEF;
	localparam int unsigned RANDOM_BYTES = 320;
	localparam string       OPEN_CH      = "([{";
	localparam string       CLOSE_CH     = ")]}";
	localparam string       IDENT_CH     = "abcxyz_019";
	localparam string       FILL_CH      = "ab x*/\\\n\"'#(){}[];";

	// Expected classification of one byte
	typedef struct packed {
		logic        outer;
		logic [5:0]  depth;
		kind_t       kind;
		logic        ovf;
	} byte_class_t;

	logic clk;
	logic arst_n;

	cns_in_if  text_ch();
	cns_out_if res_ch();

	c_source_nesting_skipper #(.MAX_NEST(MAX_NEST)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (res_ch)
	);

	// Scanner shadow state
	sub_t        sc_sub;
	logic        sc_dir;
	logic        sc_quote;
	closer_t     closer_mem [MAX_NEST];
	int unsigned nest_lvl;
	logic        ovf_flag;

	byte_class_t pending_class[$];
	byte_t       text_buf[$];
	int unsigned mismatch_cnt;
	int unsigned result_idx;
	bit          src_idle;
	bit          sink_idle;
	int unsigned hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("c_source_nesting_skipper verification failed");
		$finish;
	end

	function automatic void reset_scanner();
		sc_sub   = SUB_PLAIN;
		sc_dir   = 1'b0;
		sc_quote = 1'b0;
		nest_lvl = 0;
		ovf_flag = 1'b0;
	endfunction

	// Byte in plain code: brackets, quotes, slash, hash
	function automatic kind_t code_kind(input byte_t ch);
		closer_t c;
		if (ch == CH_SLASH) begin
			sc_sub = SUB_SLASH;
			return KIND_CODE;
		end
		if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
			sc_quote = (ch == CH_SQUOTE);
			sc_sub   = SUB_LIT;
			return KIND_LITERAL;
		end
		if (ch == CH_HASH) begin
			sc_dir = 1'b1;
			sc_sub = SUB_PLAIN;
			return KIND_DIRECTIVE;
		end
		case (ch)
			CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
				c = (ch == CH_LPAREN) ? CL_PAREN : (ch == CH_LBRACK) ? CL_BRACKET : CL_BRACE;
				if (nest_lvl < MAX_NEST) begin
					closer_mem[nest_lvl] = c;
					nest_lvl++;
				end else begin
					ovf_flag = 1'b1;
				end
			end
			CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
				c = (ch == CH_RPAREN) ? CL_PAREN : (ch == CH_RBRACK) ? CL_BRACKET : CL_BRACE;
				// only the innermost matching closer pops
				if (nest_lvl > 0 && closer_mem[nest_lvl-1] == c)
					nest_lvl--;
			end
			default: ;
		endcase
		return KIND_CODE;
	endfunction

	// Plain byte inside a directive
	function automatic kind_t dir_kind(input byte_t ch);
		if (ch == CH_NL) begin
			sc_dir = 1'b0;
			sc_sub = SUB_PLAIN;
			return KIND_DIRECTIVE;
		end
		if (ch == CH_BSLASH) begin
			sc_sub = SUB_DIRESC;
			return KIND_DIRECTIVE;
		end
		if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
			sc_quote = (ch == CH_SQUOTE);
			sc_sub   = SUB_LIT;
			return KIND_LITERAL;
		end
		if (ch == CH_SLASH)
			sc_sub = SUB_SLASH;
		return KIND_DIRECTIVE;
	endfunction

	// Classify one accepted byte and advance the shadow state
	function automatic byte_class_t classify_byte(input byte_t ch, input logic last);
		byte_class_t r;
		int unsigned depth;
		kind_t       k;
		depth = nest_lvl;
		k     = KIND_COMMENT;
		case (sc_sub)
			SUB_SLASH: begin
				if (ch == CH_SLASH) begin
					sc_sub = SUB_LINE;
				end else if (ch == CH_STAR) begin
					sc_sub = SUB_BLOCK;
				end else begin
					// lone slash: next byte handled as ordinary
					sc_sub = SUB_PLAIN;
					k = sc_dir ? dir_kind(ch) : code_kind(ch);
				end
			end
			SUB_LINE: begin
				// newline ends the comment and any directive around it
				if (ch == CH_NL) begin
					sc_sub = SUB_PLAIN;
					sc_dir = 1'b0;
				end
			end
			SUB_BLOCK: begin
				if (ch == CH_STAR)
					sc_sub = SUB_STAR;
			end
			SUB_STAR: begin
				if (ch == CH_SLASH)
					sc_sub = SUB_PLAIN;
				else if (ch != CH_STAR)
					sc_sub = SUB_BLOCK;
			end
			SUB_LIT: begin
				k = KIND_LITERAL;
				if (ch == CH_BSLASH)
					sc_sub = SUB_LITESC;
				else if (ch == (sc_quote ? CH_SQUOTE : CH_DQUOTE))
					sc_sub = SUB_PLAIN;
			end
			SUB_LITESC: begin
				k = KIND_LITERAL;
				sc_sub = SUB_LIT;
			end
			SUB_DIRESC: begin
				sc_sub = SUB_PLAIN;
				if (sc_dir)
					k = KIND_DIRECTIVE;
				else
					k = code_kind(ch);
			end
			default: begin
				k = sc_dir ? dir_kind(ch) : code_kind(ch);
			end
		endcase
		r.outer = (k == KIND_CODE && depth == 0);
		r.depth = depth[5:0];
		r.kind  = k;
		r.ovf   = ovf_flag;
		if (last)
			reset_scanner();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("%0t: result %0d %s: got %0h expected %0h", $time, result_idx, what, got, want);
		mismatch_cnt++;
	endtask

	// Input transactions feed the prediction; output transactions are checked
	always @(posedge clk) begin : class_check
		byte_class_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				result_idx++;
				if (pending_class.size() == 0) begin
					report_mismatch("unexpected result", 8'(res_ch.region_kind), 8'h00);
				end else begin
					want = pending_class.pop_front();
					if (res_ch.at_outer_level !== want.outer)
						report_mismatch("at_outer_level", 8'(res_ch.at_outer_level),
							8'(want.outer));
					if (res_ch.nest_depth !== want.depth)
						report_mismatch("nest_depth", 8'(res_ch.nest_depth), 8'(want.depth));
					if (res_ch.region_kind !== want.kind)
						report_mismatch("region_kind", 8'(res_ch.region_kind), 8'(want.kind));
					if (res_ch.depth_overflow !== want.ovf)
						report_mismatch("depth_overflow", 8'(res_ch.depth_overflow),
							8'(want.ovf));
				end
			end
			if (text_ch.valid && text_ch.ready)
				pending_class.push_back(classify_byte(text_ch.text_byte, text_ch.end_of_text));
		end
	end

	// Result side: random wait after each transaction, plus requested long holds
	initial begin : result_sink
		int unsigned wait_left;
		int unsigned hold_left;
		wait_left = 0;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (res_ch.valid && res_ch.ready)
				wait_left = sink_idle ? $urandom_range(0, 19) : 0;
			else if (wait_left > 0)
				wait_left--;
			if (hold_left > 0)
				hold_left--;
			res_ch.ready <= (wait_left == 0 && hold_left == 0);
		end
	end

	task automatic send_byte(input byte_t ch, input bit last);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid       <= 1'b1;
		text_ch.text_byte   <= ch;
		text_ch.end_of_text <= last;
		do @(posedge clk); while (!text_ch.ready);
	endtask

	task automatic send_buf(input bit close_text);
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], close_text && (i == text_buf.size() - 1));
		text_buf.delete();
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	function automatic byte_t filler_ch();
		if ($urandom_range(0, 7) == 0)
			return byte_t'($urandom_range(0, 255));
		return FILL_CH[$urandom_range(0, FILL_CH.len() - 1)];
	endfunction

	// One C-like token with random content; some are noise or left unterminated
	task automatic add_fragment();
		int unsigned n;
		n = $urandom_range(0, 5);
		case ($urandom_range(0, 15))
			0: repeat (n + 1) text_buf.push_back(IDENT_CH[$urandom_range(0, IDENT_CH.len() - 1)]);
			1, 2: text_buf.push_back(OPEN_CH[$urandom_range(0, 2)]);
			3, 4: text_buf.push_back(CLOSE_CH[$urandom_range(0, 2)]);
			5: push_str(($urandom_range(0, 1) != 0) ? " " : "\n");
			6: push_str(";");
			7: begin
				push_str("/*");
				repeat (n) text_buf.push_back(filler_ch());
				push_str(($urandom_range(0, 2) == 0) ? "**/" : "*/");
			end
			8: begin
				push_str("//");
				repeat (n) text_buf.push_back(filler_ch());
				push_str("\n");
			end
			9: begin
				push_str("\"");
				repeat (n) begin
					if ($urandom_range(0, 3) == 0)
						push_str("\\\"");
					else
						text_buf.push_back(filler_ch());
				end
				push_str("\"");
			end
			10: begin
				push_str("'");
				if ($urandom_range(0, 1) != 0)
					push_str("\\");
				text_buf.push_back(filler_ch());
				push_str("'");
			end
			11, 12: begin
				push_str("#");
				repeat (n + 1) begin
					case ($urandom_range(0, 5))
						0: push_str("\\\n");
						1: push_str("\"s\\\"\"");
						2: push_str("/*x*/");
						3: push_str("'c'");
						4: push_str("/x");
						default: text_buf.push_back(filler_ch());
					endcase
				end
				push_str(($urandom_range(0, 2) == 0) ? "//x\n" : "\n");
			end
			13: begin
				push_str("/");
				text_buf.push_back(filler_ch());
			end
			default: repeat (n + 1) text_buf.push_back(byte_t'($urandom_range(0, 255)));
		endcase
	endtask

	// Byte extremes, unmatched closers, lone slash, comment and literal edges
	task automatic test_code_regions();
		src_idle  = 1;
		sink_idle = 1;
		text_buf.push_back(8'h00);
		text_buf.push_back(8'hFF);
		push_str(")(])/x/*/*/'\\''\"\n\"");
		send_buf(1);
	endtask

	// Directive with escaped newline, literal, and a line comment that ends it
	task automatic test_directive();
		push_str("#\\\n\"\"//\n");
		send_buf(1);
	endtask

	// Fill the closer stack near or past its depth, then unwind
	task automatic test_deep_nesting();
		int unsigned opened[$];
		int unsigned depth;
		int unsigned idx;
		for (int k = 0; k < 4; k++) begin
			depth = (k == 0) ? MAX_NEST + 2 : $urandom_range(MAX_NEST - 4, MAX_NEST + 2);
			opened.delete();
			repeat (depth) begin
				idx = $urandom_range(0, 2);
				opened.push_back(idx);
				text_buf.push_back(OPEN_CH[idx]);
				if ($urandom_range(0, 5) == 0)
					push_str("/*(*/");
			end
			// a wrong closer first, then the matching ones, then one at depth zero
			text_buf.push_back(CLOSE_CH[$urandom_range(0, 2)]);
			for (int i = opened.size() - 1; i >= 0; i--)
				text_buf.push_back(CLOSE_CH[opened[i]]);
			push_str(")");
			send_buf(1);
		end
	endtask

	// Long hold on the result side while bytes keep coming, then drain
	task automatic test_backpressure();
		src_idle  = 0;
		sink_idle = 0;
		hold_req  = 64;
		while (text_buf.size() < 48)
			add_fragment();
		send_buf(1);
		// sender pauses until every result has arrived
		text_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_class.size() != 0);
		while (text_buf.size() < 100)
			add_fragment();
		send_buf(1);
		src_idle  = 1;
		sink_idle = 1;
	endtask

	task automatic test_random_text();
		int unsigned sent;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 40)) add_fragment();
			sent += text_buf.size();
			send_buf($urandom_range(0, 3) != 0);
		end
		src_idle  = 1;
		sink_idle = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		text_ch.valid       <= 1'b0;
		text_ch.text_byte   <= '0;
		text_ch.end_of_text <= 1'b0;
		src_idle     = 1;
		sink_idle    = 1;
		hold_req     = 0;
		mismatch_cnt = 0;
		result_idx   = 0;
		reset_scanner();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_code_regions();
		test_directive();
		test_deep_nesting();
		test_backpressure();
		test_random_text();

		// drain, then stay quiet to catch stray results
		text_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_class.size() != 0);
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("c_source_nesting_skipper verification clean");
		end else begin
			$display("c_source_nesting_skipper verification failed");
		end
		$finish;
	end

endmodule
